### sv/base64url_stream_encoder_top_defines.svh
`ifndef BASE64URL_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64URL_STREAM_ENCODER_TOP_DEFINES_SVH

// check that holds outside reset
`define B64U_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds across reset
`define B64U_CHECK_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/b64u_pkg.sv
package b64u_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  localparam logic [1:0] PH_ZERO = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_TWO  = 2'd2;

  // up to four characters produced by one input byte
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      cnt_m1;
    logic            last;
  } grp_t;

  // url-safe alphabet lookup
  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] r;
    priority if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2D;
    end else begin
      r = 8'h5F;
    end
    return r;
  endfunction

endpackage

### sv/base64url_stream_encoder_top.sv
// path: a byte's first character passes the queue entry, the current-group register and the output register
// throughput: one character per cycle while char_ready is high and groups are queued, set by the output
//   serialiser; a byte yields one or two characters mid-group and up to four on a final byte
// a two-entry group queue sits between byte intake and the serialiser
// reset: synchronous, clears group position, leftover bits, queue and output valid
module base64url_stream_encoder_top import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic       char_valid,
  input  logic       char_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  logic push_valid;
  logic push_ready;
  grp_t push_grp;
  logic pop_valid;
  logic pop_ready;
  grp_t pop_grp;

  b64u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .is_last    (is_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_grp   (push_grp)
  );

  b64u_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_grp   (push_grp),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_grp    (pop_grp)
  );

  b64u_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_grp    (pop_grp),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .out_char   (out_char),
    .out_last   (out_last)
  );

endmodule

### sv/b64u_front.sv
module b64u_front import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] data_byte,
  input  logic       is_last,
  output logic       push_valid,
  input  logic       push_ready,
  output grp_t       push_grp
);

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [3:0] carry;
  logic [3:0] carry_next;
  logic       take;

  assign push_valid = byte_valid;
  assign byte_ready = push_ready;
  assign take       = byte_valid && push_ready;

  always_comb begin
    push_grp       = '0;
    push_grp.last  = is_last;
    phase_next     = phase;
    carry_next     = carry;
    unique case (phase)
      PH_ONE: begin
        push_grp.chars[0] = sym({carry[1:0], data_byte[7:4]});
        if (is_last) begin
          push_grp.chars[1] = sym({data_byte[3:0], 2'b00});
          push_grp.chars[2] = PAD_CHAR;
          push_grp.cnt_m1   = 2'd2;
          phase_next        = PH_ZERO;
          carry_next        = '0;
        end else begin
          push_grp.cnt_m1 = 2'd0;
          phase_next      = PH_TWO;
          carry_next      = data_byte[3:0];
        end
      end
      PH_TWO: begin
        push_grp.chars[0] = sym({carry, data_byte[7:6]});
        push_grp.chars[1] = sym(data_byte[5:0]);
        push_grp.cnt_m1   = 2'd1;
        phase_next        = PH_ZERO;
        carry_next        = '0;
      end
      default: begin
        // unused phase code behaves as the start of a group
        push_grp.chars[0] = sym(data_byte[7:2]);
        if (is_last) begin
          push_grp.chars[1] = sym({data_byte[1:0], 4'b0000});
          push_grp.chars[2] = PAD_CHAR;
          push_grp.chars[3] = PAD_CHAR;
          push_grp.cnt_m1   = 2'd3;
          phase_next        = PH_ZERO;
          carry_next        = '0;
        end else begin
          push_grp.cnt_m1 = 2'd0;
          phase_next      = PH_ONE;
          carry_next      = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_ZERO;
      carry <= '0;
    end else if (take) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

endmodule

### sv/b64u_queue.sv
module b64u_queue import b64u_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  grp_t push_grp,
  output logic pop_valid,
  input  logic pop_ready,
  output grp_t pop_grp
);

  grp_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_grp    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### sv/b64u_back.sv
module b64u_back import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  grp_t       pop_grp,
  output logic       char_valid,
  input  logic       char_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  grp_t       cur;
  logic [1:0] idx;
  logic       busy;
  logic       slot_free;
  logic       emit;
  logic       end_of_grp;
  logic       load;

  assign slot_free  = !char_valid || char_ready;
  assign emit       = busy && slot_free;
  assign end_of_grp = (idx == cur.cnt_m1);
  // take the next group when idle or as the current one hands out its final character
  assign pop_ready  = !busy || (emit && end_of_grp);
  assign load       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= '0;
      char_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        char_valid <= busy;
      end
      if (emit) begin
        idx <= idx + 2'd1;
      end
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (emit && end_of_grp) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= pop_grp;
    end
    if (emit) begin
      out_char <= cur.chars[idx];
      out_last <= cur.last && end_of_grp;
    end
  end

endmodule

### sv/b64u_checker.sv
`include "base64url_stream_encoder_top_defines.svh"

module b64u_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_ready,
  input logic [7:0] data_byte,
  input logic       is_last,
  input logic       char_valid,
  input logic       char_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  logic       alpha_ok;
  logic       in_stall;
  logic       out_stall;
  logic [8:0] in_word;
  logic [8:0] out_word;

  assign in_stall  = byte_valid && !byte_ready;
  assign out_stall = char_valid && !char_ready;
  assign in_word   = {data_byte, is_last};
  assign out_word  = {out_char, out_last};

  assign alpha_ok = ((out_char >= 8'h41) && (out_char <= 8'h5A)) ||
                    ((out_char >= 8'h61) && (out_char <= 8'h7A)) ||
                    ((out_char >= 8'h30) && (out_char <= 8'h39)) ||
                    (out_char == 8'h2D) || (out_char == 8'h5F) || (out_char == 8'h3D);

  `B64U_CHECK_RST(a_rst_idle, clk, rst |=> !char_valid, "output valid after reset")
  `B64U_CHECK_RST(a_rst_ready, clk, rst |=> byte_ready, "input not ready after reset")
  `B64U_CHECK(a_alphabet, clk, rst, char_valid |-> alpha_ok, "character outside alphabet")
  `B64U_CHECK(a_hold, clk, rst, out_stall |=> (char_valid && $stable(out_word)), "word held")
  `B64U_CHECK(a_in_hold, clk, rst, in_stall |=> (byte_valid && $stable(in_word)), "input held")

endmodule

bind base64url_stream_encoder_top b64u_checker u_b64u_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_ready (byte_ready),
  .data_byte  (data_byte),
  .is_last    (is_last),
  .char_valid (char_valid),
  .char_ready (char_ready),
  .out_char   (out_char),
  .out_last   (out_last)
);
